@@ src/sel_pkg.sv @@
// ----------------------------------------------------------------------------
// Speed exclusion rate limiter package
// Shared widths, register indexes, reset values and the Q16.16 saturation
// helper used by the limiter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sel_pkg;

    // Field and register widths.
    localparam int unsigned QW       = 32;  // signed Q16.16 word
    localparam int unsigned RW       = 31;  // unsigned Q15.16 register
    localparam int unsigned CFG_AW   = 3;   // register index width
    localparam int unsigned IN_DW    = 40;  // input tdata, padded to bytes
    localparam int unsigned OUT_DW   = 72;  // output tdata, padded to bytes
    localparam int unsigned PROD_W   = 64;  // full product of the multiplier
    localparam int unsigned PQ_W     = 48;  // product after the Q16 shift

    // Register indexes.
    localparam logic [CFG_AW-1:0] REG_EXCL_CENTRE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_EXCL_WIDTH  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RATE_BOUND  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TICK_PERIOD = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GEAR_RATIO  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_GEAR_INV    = 3'd5;

    // Register reset values.
    localparam logic [RW-1:0] RST_EXCL_CENTRE = 31'd0;
    localparam logic [RW-1:0] RST_EXCL_WIDTH  = 31'd0;
    localparam logic [RW-1:0] RST_RATE_BOUND  = 31'd65536;
    localparam logic [RW-1:0] RST_TICK_PERIOD = 31'd655;
    localparam logic [RW-1:0] RST_GEAR_RATIO  = 31'd65536;
    localparam logic [RW-1:0] RST_GEAR_INV    = 31'd65536;

    // Saturation bounds of a signed Q16.16 word.
    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // Saturate a signed 48-bit value to the signed 32-bit range.
    function automatic logic signed [QW-1:0] sat48(input logic signed [PQ_W-1:0] x);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[PQ_W-1:QW-1];
        hi_zeros = ~|x[PQ_W-1:QW-1];
        if (hi_ones || hi_zeros) begin
            sat48 = x[QW-1:0];
        end else if (x[PQ_W-1]) begin
            sat48 = Q_MIN;
        end else begin
            sat48 = Q_MAX;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/speed_exclusion_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// Speed exclusion rate limiter
// Converts a generator speed reference to shaft speed, holds it outside an
// excluded speed band, bounds its change per tick and scales it back.
// ----------------------------------------------------------------------------
// Each accepted word runs through one shared bit-serial multiplier three
// times (shaft speed, step bound, output scaling), one multiplier bit per
// cycle. On its way to the result register a word passes the three
// multiplications and four control steps (shaft saturation, band test,
// limiter step and the result load). The input is ready again in the cycle
// after the load; no new word is taken while one is in process. A new word is
// accepted once the previous one has reached the output register, even if
// that result has not yet been taken; a result that is still waiting holds
// the next word in its last step. Configuration registers may be written at
// any time the block is idle and take effect on the next word.
`default_nettype none

module speed_exclusion_rate_limiter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration write port.
    input  wire                          i_cfg_wr_en,
    input  wire [sel_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire [sel_pkg::RW-1:0]        i_cfg_wr_data,
    // Input stream.
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [31:0] gen_ref_speed, [32] restart_flag, [33] first_call, [39:34] zero
    input  wire [sel_pkg::IN_DW-1:0]     s_axis_tdata,
    // Output stream.
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [31:0] gen_ref_out, [32] in_band, [64:33] shaft_ref_limited, [71:65] zero
    output logic [sel_pkg::OUT_DW-1:0]   m_axis_tdata
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_SHAFT = 3'd1;
    localparam logic [2:0] S_SHAFT     = 3'd2;
    localparam logic [2:0] S_MUL_BOUND = 3'd3;
    localparam logic [2:0] S_BAND      = 3'd4;
    localparam logic [2:0] S_LIMIT     = 3'd5;
    localparam logic [2:0] S_MUL_OUT   = 3'd6;
    localparam logic [2:0] S_WRITE     = 3'd7;

    localparam logic [4:0] MUL_LAST = 5'(sel_pkg::RW - 1);

    // Configuration registers.
    logic [sel_pkg::RW-1:0] r_excl_centre;
    logic [sel_pkg::RW-1:0] r_excl_width;
    logic [sel_pkg::RW-1:0] r_rate_bound;
    logic [sel_pkg::RW-1:0] r_tick_period;
    logic [sel_pkg::RW-1:0] r_gear_ratio;
    logic [sel_pkg::RW-1:0] r_gear_inv;

    // Control and state.
    logic [2:0]                   r_state, n_state;
    logic [4:0]                   r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;
    logic signed [sel_pkg::QW-1:0] r_held, n_held;
    logic signed [sel_pkg::QW-1:0] r_lim, n_lim;

    // Word payload and intermediate values.
    logic                         r_restart, n_restart;
    logic                         r_first, n_first;
    logic signed [sel_pkg::QW-1:0] r_shaft, n_shaft;
    logic signed [sel_pkg::QW-1:0] r_target, n_target;
    logic                         r_inside, n_inside;
    logic [sel_pkg::PQ_W-3:0]     r_bound, n_bound;
    logic [sel_pkg::OUT_DW-1:0]   r_out_data, n_out_data;

    // Bit-serial multiplier: signed 32-bit multiplicand, unsigned 31-bit
    // multiplier shifted out LSB first, product builds in {acc, b}.
    logic signed [sel_pkg::QW-1:0] r_mul_a, n_mul_a;
    logic [sel_pkg::RW-1:0]        r_mul_b, n_mul_b;
    logic signed [sel_pkg::QW:0]   r_acc, n_acc;
    logic signed [sel_pkg::QW+1:0] mul_sum;
    logic signed [sel_pkg::PROD_W-1:0] prod;
    logic signed [sel_pkg::PQ_W-1:0]   prod_q;
    logic signed [sel_pkg::QW-1:0]     prod_sat;

    // Band and limiter arithmetic.
    logic signed [sel_pkg::QW+1:0] band_lo, band_hi, shaft_x, centre_x;
    logic signed [sel_pkg::QW-1:0] edge_val;
    logic                          band_hit;
    logic signed [sel_pkg::QW:0]   delta;
    logic signed [sel_pkg::PQ_W-1:0] delta_x, bound_x, step;
    logic signed [sel_pkg::QW-1:0] lim_next;

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excl_centre <= sel_pkg::RST_EXCL_CENTRE;
            r_excl_width  <= sel_pkg::RST_EXCL_WIDTH;
            r_rate_bound  <= sel_pkg::RST_RATE_BOUND;
            r_tick_period <= sel_pkg::RST_TICK_PERIOD;
            r_gear_ratio  <= sel_pkg::RST_GEAR_RATIO;
            r_gear_inv    <= sel_pkg::RST_GEAR_INV;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                sel_pkg::REG_EXCL_CENTRE: r_excl_centre <= i_cfg_wr_data;
                sel_pkg::REG_EXCL_WIDTH:  r_excl_width  <= i_cfg_wr_data;
                sel_pkg::REG_RATE_BOUND:  r_rate_bound  <= i_cfg_wr_data;
                sel_pkg::REG_TICK_PERIOD: r_tick_period <= i_cfg_wr_data;
                sel_pkg::REG_GEAR_RATIO:  r_gear_ratio  <= i_cfg_wr_data;
                sel_pkg::REG_GEAR_INV:    r_gear_inv    <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // One multiplier step and the finished product after the last step.
    always_comb begin
        mul_sum  = {r_acc[sel_pkg::QW], r_acc}
                 + (r_mul_b[0] ? {{2{r_mul_a[sel_pkg::QW-1]}}, r_mul_a}
                               : {(sel_pkg::QW+2){1'b0}});
        prod     = {r_acc, r_mul_b};
        prod_q   = prod[sel_pkg::PROD_W-1:16];
        prod_sat = sel_pkg::sat48(prod_q);
    end

    // Band test on the registered shaft speed.
    always_comb begin
        centre_x = {3'b000, r_excl_centre};
        band_lo  = centre_x - {4'b0000, r_excl_width[sel_pkg::RW-1:1]};
        band_hi  = centre_x + {4'b0000, r_excl_width[sel_pkg::RW-1:1]};
        shaft_x  = {{2{r_shaft[sel_pkg::QW-1]}}, r_shaft};
        band_hit = (shaft_x > band_lo) && (shaft_x < band_hi);
        // Nearer band edge; the upper edge may overflow and saturates.
        if (shaft_x > centre_x) begin
            edge_val = band_hi[sel_pkg::QW+1:sel_pkg::QW-1] != 3'b000
                     ? sel_pkg::Q_MAX : band_hi[sel_pkg::QW-1:0];
        end else begin
            edge_val = band_lo[sel_pkg::QW-1:0];
        end
    end

    // Limiter step: clamp the change to the bound.
    always_comb begin
        delta   = {r_target[sel_pkg::QW-1], r_target} - {r_lim[sel_pkg::QW-1], r_lim};
        delta_x = {{(sel_pkg::PQ_W-sel_pkg::QW-1){delta[sel_pkg::QW]}}, delta};
        bound_x = {2'b00, r_bound};
        if (delta_x > bound_x) begin
            step = bound_x;
        end else if (delta_x < -bound_x) begin
            step = -bound_x;
        end else begin
            step = delta_x;
        end
        lim_next = r_lim + step[sel_pkg::QW-1:0];
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_held      = r_held;
        n_lim       = r_lim;
        n_restart   = r_restart;
        n_first     = r_first;
        n_shaft     = r_shaft;
        n_target    = r_target;
        n_inside    = r_inside;
        n_bound     = r_bound;
        n_out_data  = r_out_data;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_acc       = r_acc;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_restart = s_axis_tdata[32];
                    n_first   = s_axis_tdata[33];
                    n_mul_a   = s_axis_tdata[sel_pkg::QW-1:0];
                    n_mul_b   = r_gear_inv;
                    n_acc     = '0;
                    n_cnt     = '0;
                    n_state   = S_MUL_SHAFT;
                end
            end
            S_MUL_SHAFT, S_MUL_BOUND, S_MUL_OUT: begin
                n_acc   = mul_sum[sel_pkg::QW+1:1];
                n_mul_b = {mul_sum[0], r_mul_b[sel_pkg::RW-1:1]};
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == MUL_LAST) begin
                    if (r_state == S_MUL_SHAFT) begin
                        n_state = S_SHAFT;
                    end else if (r_state == S_MUL_BOUND) begin
                        n_state = S_BAND;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_SHAFT: begin
                n_shaft = prod_sat;
                n_mul_a = {1'b0, r_rate_bound};
                n_mul_b = r_tick_period;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = S_MUL_BOUND;
            end
            S_BAND: begin
                // The bound is non-negative and below 2^46.
                n_bound  = prod_q[sel_pkg::PQ_W-3:0];
                n_inside = band_hit;
                if (band_hit) begin
                    n_target = r_restart ? edge_val : r_held;
                end else begin
                    n_target = r_shaft;
                end
                n_held = n_target;
                if (r_first || r_restart) begin
                    n_lim = n_target;
                end
                n_state = S_LIMIT;
            end
            S_LIMIT: begin
                n_lim   = lim_next;
                n_mul_a = lim_next;
                n_mul_b = r_gear_ratio;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = S_MUL_OUT;
            end
            S_WRITE: begin
                // Load the result once the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_data  = {7'b0000000, r_lim, r_inside, prod_sat};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_lim       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_held      <= n_held;
            r_lim       <= n_lim;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_restart  <= n_restart;
        r_first    <= n_first;
        r_shaft    <= n_shaft;
        r_target   <= n_target;
        r_inside   <= n_inside;
        r_bound    <= n_bound;
        r_out_data <= n_out_data;
        r_mul_a    <= n_mul_a;
        r_mul_b    <= n_mul_b;
        r_acc      <= n_acc;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
